/* rtl/sll_pkg.sv */
// Shared definitions for the linked list block: action codes, default sizes
// and the result record passed from the sequencer to the output stage.
// No dependencies.
package sll_pkg;

    // Default pool size and stored value width
    localparam int POOL_NODES_DEF = 256;
    localparam int VALUE_BITS_DEF = 32;

    // Width of the value fields on the ports
    localparam int PORT_VALUE_BITS = 32;
    localparam int ACTION_BITS     = 4;

    // Action codes
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR     = 4'd0;
    localparam logic [ACTION_BITS-1:0] ACT_INS_HEAD  = 4'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CUR_HEAD  = 4'd2;
    localparam logic [ACTION_BITS-1:0] ACT_DEL_HEAD  = 4'd3;
    localparam logic [ACTION_BITS-1:0] ACT_DEL_AFTER = 4'd4;
    localparam logic [ACTION_BITS-1:0] ACT_INS_AFTER = 4'd5;
    localparam logic [ACTION_BITS-1:0] ACT_OVERWRITE = 4'd6;
    localparam logic [ACTION_BITS-1:0] ACT_ADVANCE   = 4'd7;
    localparam logic [ACTION_BITS-1:0] ACT_PEEK      = 4'd8;

    // One result transaction
    typedef struct packed {
        logic                              head_present;
        logic signed [PORT_VALUE_BITS-1:0] head_value;
        logic                              cursor_active;
        logic signed [PORT_VALUE_BITS-1:0] cursor_value;
        logic                              out_of_space;
    } res_t;

endpackage

/* rtl/sll_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module sll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sll_seq.sv */
// Action sequencer for the linked list: pointer registers, free list and
// the read-modify-write steps on the value and link memories.
// Depends on sll_pkg and sll_ram.
module sll_seq
    import sll_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ACTION_BITS-1:0]            in_action,
    input  logic signed [PORT_VALUE_BITS-1:0] in_value,
    output logic                              res_valid,
    input  logic                              res_ready,
    output res_t                              res
);

    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int LNK_W = IDX_W + 1;             // top bit: link valid
    localparam int CNT_W = $clog2(POOL_NODES + 1);
    localparam int EXT_W = (VALUE_BITS > PORT_VALUE_BITS) ? VALUE_BITS : PORT_VALUE_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LINK1 = 3'd1;
    localparam logic [2:0] S_LINK2 = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_VAL   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // Control state
    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic             head_vld_reg, head_vld_next;
    logic [IDX_W-1:0] cur_reg, cur_next;
    logic             cur_vld_reg, cur_vld_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic             free_vld_reg, free_vld_next;
    logic [CNT_W-1:0] hwm_reg, hwm_next;

    // Payload and scratch
    logic [ACTION_BITS-1:0]       act_reg, act_next;
    logic signed [VALUE_BITS-1:0] val_reg, val_next;
    logic signed [VALUE_BITS-1:0] head_val_reg, head_val_next;
    logic signed [VALUE_BITS-1:0] cur_val_reg, cur_val_next;
    logic                         full_reg, full_next;
    logic [IDX_W-1:0]             tmp_reg, tmp_next;
    logic [LNK_W-1:0]             lnk_reg, lnk_next;
    logic [IDX_W-1:0]             wa_reg, wa_next;
    logic [LNK_W-1:0]             wd_reg, wd_next;

    // Memory ports
    logic                  lk_we, lk_re, vl_we, vl_re;
    logic [IDX_W-1:0]      lk_waddr, lk_raddr, vl_waddr, vl_raddr;
    logic [LNK_W-1:0]      lk_wdata, lk_rdata;
    logic [VALUE_BITS-1:0] vl_wdata, vl_rdata;

    logic signed [VALUE_BITS-1:0] in_val;
    logic                         rd_vld;
    logic [IDX_W-1:0]             rd_idx;
    logic                         hwm_room;
    logic [IDX_W-1:0]             hwm_idx;

    sll_ram #(.WIDTH(LNK_W), .DEPTH(POOL_NODES)) u_link_ram (
        .aclk  (aclk),
        .we    (lk_we),
        .waddr (lk_waddr),
        .wdata (lk_wdata),
        .re    (lk_re),
        .raddr (lk_raddr),
        .rdata (lk_rdata)
    );

    sll_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_value_ram (
        .aclk  (aclk),
        .we    (vl_we),
        .waddr (vl_waddr),
        .wdata (vl_wdata),
        .re    (vl_re),
        .raddr (vl_raddr),
        .rdata (vl_rdata)
    );

    // Sign extend the port value, keep the stored width
    assign in_val   = VALUE_BITS'(EXT_W'(in_value));
    assign rd_vld   = lk_rdata[IDX_W];
    assign rd_idx   = lk_rdata[IDX_W-1:0];
    assign hwm_room = (hwm_reg < CNT_W'(POOL_NODES));
    assign hwm_idx  = hwm_reg[IDX_W-1:0];
    assign in_ready = (state_reg == S_IDLE);

    // Sequence one action through the memories
    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        head_vld_next = head_vld_reg;
        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        free_next     = free_reg;
        free_vld_next = free_vld_reg;
        hwm_next      = hwm_reg;
        act_next      = act_reg;
        val_next      = val_reg;
        head_val_next = head_val_reg;
        cur_val_next  = cur_val_reg;
        full_next     = full_reg;
        tmp_next      = tmp_reg;
        lnk_next      = lnk_reg;
        wa_next       = wa_reg;
        wd_next       = wd_reg;
        lk_we         = 1'b0;
        lk_waddr      = '0;
        lk_wdata      = '0;
        lk_re         = 1'b0;
        lk_raddr      = '0;
        vl_we         = 1'b0;
        vl_waddr      = '0;
        vl_wdata      = '0;
        vl_re         = 1'b0;
        vl_raddr      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    act_next   = in_action;
                    val_next   = in_val;
                    full_next  = 1'b0;
                    state_next = S_OUT;
                    case (in_action) inside
                        ACT_CLEAR: begin
                            head_vld_next = 1'b0;
                            cur_vld_next  = 1'b0;
                            free_vld_next = 1'b0;
                            hwm_next      = '0;
                        end
                        ACT_INS_HEAD: begin
                            if (free_vld_reg) begin
                                // Pop the free list: fetch its next link
                                lk_re      = 1'b1;
                                lk_raddr   = free_reg;
                                state_next = S_LINK1;
                            end else if (hwm_room) begin
                                lk_we         = 1'b1;
                                lk_waddr      = hwm_idx;
                                lk_wdata      = {head_vld_reg, head_reg};
                                vl_we         = 1'b1;
                                vl_waddr      = hwm_idx;
                                vl_wdata      = in_val;
                                head_next     = hwm_idx;
                                head_vld_next = 1'b1;
                                head_val_next = in_val;
                                hwm_next      = hwm_reg + CNT_W'(1);
                            end else begin
                                full_next = 1'b1;
                            end
                        end
                        ACT_CUR_HEAD: begin
                            cur_next     = head_reg;
                            cur_vld_next = head_vld_reg;
                            cur_val_next = head_val_reg;
                        end
                        ACT_DEL_HEAD: begin
                            if (head_vld_reg) begin
                                lk_re      = 1'b1;
                                lk_raddr   = head_reg;
                                state_next = S_LINK1;
                            end
                        end
                        ACT_DEL_AFTER, ACT_INS_AFTER, ACT_ADVANCE: begin
                            if (cur_vld_reg) begin
                                lk_re      = 1'b1;
                                lk_raddr   = cur_reg;
                                state_next = S_LINK1;
                            end
                        end
                        ACT_OVERWRITE: begin
                            if (cur_vld_reg) begin
                                vl_we        = 1'b1;
                                vl_waddr     = cur_reg;
                                vl_wdata     = in_val;
                                cur_val_next = in_val;
                                if (head_vld_reg && (head_reg == cur_reg)) begin
                                    head_val_next = in_val;
                                end
                            end
                        end
                        default: begin
                            // peek and unused codes leave the list alone
                        end
                    endcase
                end
            end

            S_LINK1: begin
                state_next = S_OUT;
                case (act_reg)
                    ACT_INS_HEAD: begin
                        free_next     = rd_idx;
                        free_vld_next = rd_vld;
                        lk_we         = 1'b1;
                        lk_waddr      = free_reg;
                        lk_wdata      = {head_vld_reg, head_reg};
                        vl_we         = 1'b1;
                        vl_waddr      = free_reg;
                        vl_wdata      = val_reg;
                        head_next     = free_reg;
                        head_vld_next = 1'b1;
                        head_val_next = val_reg;
                    end
                    ACT_DEL_HEAD: begin
                        // Push the old head onto the free list
                        lk_we         = 1'b1;
                        lk_waddr      = head_reg;
                        lk_wdata      = {free_vld_reg, free_reg};
                        free_next     = head_reg;
                        free_vld_next = 1'b1;
                        if (cur_vld_reg && (cur_reg == head_reg)) begin
                            cur_vld_next = 1'b0;
                        end
                        head_next     = rd_idx;
                        head_vld_next = rd_vld;
                        if (rd_vld) begin
                            vl_re      = 1'b1;
                            vl_raddr   = rd_idx;
                            state_next = S_VAL;
                        end
                    end
                    ACT_DEL_AFTER: begin
                        if (rd_vld) begin
                            tmp_next   = rd_idx;
                            lk_re      = 1'b1;
                            lk_raddr   = rd_idx;
                            state_next = S_LINK2;
                        end
                    end
                    ACT_INS_AFTER: begin
                        lnk_next = lk_rdata;
                        if (free_vld_reg) begin
                            tmp_next   = free_reg;
                            lk_re      = 1'b1;
                            lk_raddr   = free_reg;
                            state_next = S_LINK2;
                        end else if (hwm_room) begin
                            lk_we      = 1'b1;
                            lk_waddr   = hwm_idx;
                            lk_wdata   = lk_rdata;
                            vl_we      = 1'b1;
                            vl_waddr   = hwm_idx;
                            vl_wdata   = val_reg;
                            hwm_next   = hwm_reg + CNT_W'(1);
                            wa_next    = cur_reg;
                            wd_next    = {1'b1, hwm_idx};
                            state_next = S_WRITE;
                        end else begin
                            full_next = 1'b1;
                        end
                    end
                    ACT_ADVANCE: begin
                        cur_next     = rd_idx;
                        cur_vld_next = rd_vld;
                        if (rd_vld) begin
                            vl_re      = 1'b1;
                            vl_raddr   = rd_idx;
                            state_next = S_VAL;
                        end
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_LINK2: begin
                state_next = S_WRITE;
                case (act_reg)
                    ACT_DEL_AFTER: begin
                        // Unlink the node, then free it in the write step
                        lk_we         = 1'b1;
                        lk_waddr      = cur_reg;
                        lk_wdata      = lk_rdata;
                        wa_next       = tmp_reg;
                        wd_next       = {free_vld_reg, free_reg};
                        free_next     = tmp_reg;
                        free_vld_next = 1'b1;
                    end
                    ACT_INS_AFTER: begin
                        lk_we         = 1'b1;
                        lk_waddr      = tmp_reg;
                        lk_wdata      = lnk_reg;
                        vl_we         = 1'b1;
                        vl_waddr      = tmp_reg;
                        vl_wdata      = val_reg;
                        free_next     = rd_idx;
                        free_vld_next = rd_vld;
                        wa_next       = cur_reg;
                        wd_next       = {1'b1, tmp_reg};
                    end
                    default: begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_WRITE: begin
                lk_we      = 1'b1;
                lk_waddr   = wa_reg;
                lk_wdata   = wd_reg;
                state_next = S_OUT;
            end

            S_VAL: begin
                if (act_reg == ACT_DEL_HEAD) begin
                    head_val_next = vl_rdata;
                end else begin
                    cur_val_next = vl_rdata;
                end
                state_next = S_OUT;
            end

            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            head_vld_reg <= 1'b0;
            cur_vld_reg  <= 1'b0;
            free_vld_reg <= 1'b0;
            hwm_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            head_vld_reg <= head_vld_next;
            cur_vld_reg  <= cur_vld_next;
            free_vld_reg <= free_vld_next;
            hwm_reg      <= hwm_next;
        end
    end

    // Pointer and payload registers
    always_ff @(posedge aclk) begin
        head_reg     <= head_next;
        cur_reg      <= cur_next;
        free_reg     <= free_next;
        act_reg      <= act_next;
        val_reg      <= val_next;
        head_val_reg <= head_val_next;
        cur_val_reg  <= cur_val_next;
        full_reg     <= full_next;
        tmp_reg      <= tmp_next;
        lnk_reg      <= lnk_next;
        wa_reg       <= wa_next;
        wd_reg       <= wd_next;
    end

    // Result: zero the value of an absent node, resize to the port width
    assign res_valid         = (state_reg == S_OUT);
    assign res.head_present  = head_vld_reg;
    assign res.head_value    = head_vld_reg ?
                               PORT_VALUE_BITS'(EXT_W'(head_val_reg)) : '0;
    assign res.cursor_active = cur_vld_reg;
    assign res.cursor_value  = cur_vld_reg ?
                               PORT_VALUE_BITS'(EXT_W'(cur_val_reg)) : '0;
    assign res.out_of_space  = full_reg;

    // An accepted transaction always leaves the idle state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after an accepted transaction");

    // Only an insert reports a full pool
    assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res.out_of_space) |->
        (act_reg == ACT_INS_HEAD || act_reg == ACT_INS_AFTER))
        else $error("out_of_space on an action that is not an insert");

    // The fill count never passes the pool size
    assert property (@(posedge aclk) disable iff (!aresetn)
        hwm_reg <= CNT_W'(POOL_NODES))
        else $error("fill count beyond pool size");

    // Free nodes only come from nodes handed out before
    assert property (@(posedge aclk) disable iff (!aresetn)
        free_vld_reg |-> (hwm_reg != '0))
        else $error("free list holds a node that was never allocated");

    // Link patches only happen while the cursor is on a node
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> cur_vld_reg)
        else $error("link write step without an active cursor");

endmodule

/* rtl/singly_linked_list_with_cursor.sv */
// Singly linked list of signed values in a fixed node pool, with one cursor.
// Top level: sequencer plus result output register.
// Depends on sll_pkg, sll_seq and sll_ram.
//
// Usage:
//   The input channel (s_valid/s_ready, s_action, s_value) takes one action
//   per transaction; the result channel (m_valid/m_ready) returns exactly one
//   transaction per action with the list state after it: head presence and
//   value, cursor activity and value, and whether an insert found the pool full.
//   The sequencer works one action at a time and accepts only while idle: peek,
//   clear, cursor-to-head, overwrite and any action on an empty list or inactive
//   cursor go straight to the result step, as does an insert head that takes a
//   fresh node or finds the pool full. Each dependent link fetch, the value fetch
//   for a new head or cursor node and the second link write add one step each.
//   The result is registered into the output register that drives m_valid.
//   Freed nodes sit on a free list threaded through the link memory; untouched
//   nodes come from a fill count, so reset and clear take effect at once.
//   After reset the list is empty and the cursor inactive. A stalled result
//   waits in the output register while the sequencer works the next action.
module singly_linked_list_with_cursor
    import sll_pkg::*;
#(
    parameter int POOL_NODES = POOL_NODES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ACTION_BITS-1:0]            s_action,
    input  logic signed [PORT_VALUE_BITS-1:0] s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_head_present,
    output logic signed [PORT_VALUE_BITS-1:0] m_head_value,
    output logic                              m_cursor_active,
    output logic signed [PORT_VALUE_BITS-1:0] m_cursor_value,
    output logic                              m_out_of_space
);

    logic res_valid;
    logic res_ready;
    res_t res;
    logic m_valid_reg, m_valid_next;
    res_t out_reg;

    sll_seq #(
        .POOL_NODES (POOL_NODES),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_action (s_action),
        .in_value  (s_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Take a new result when the output register is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the result payload until the transaction completes
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_head_present  = out_reg.head_present;
    assign m_head_value    = out_reg.head_value;
    assign m_cursor_active = out_reg.cursor_active;
    assign m_cursor_value  = out_reg.cursor_value;
    assign m_out_of_space  = out_reg.out_of_space;

endmodule

/* bench/tb_singly_linked_list_with_cursor.sv */
`timescale 1ns / 1ps
// Self-checking bench for singly_linked_list_with_cursor: directed and random list
// actions under varying valid/ready pressure, checked against an in-bench list model.
// Depends on sll_pkg and the singly_linked_list_with_cursor RTL.
module tb_singly_linked_list_with_cursor;
    import sll_pkg::*;

    localparam int POOL = POOL_NODES_DEF;
    localparam int PTR_BITS = $clog2(POOL + 1);
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;

    // Reserved action codes behave as peek
    localparam logic [ACTION_BITS-1:0] ACT_RSVD_FIRST = 4'd9;
    localparam logic [ACTION_BITS-1:0] ACT_RSVD_LAST  = 4'd15;

    localparam logic signed [PORT_VALUE_BITS-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [PORT_VALUE_BITS-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef logic [PTR_BITS-1:0] ptr_t;
    localparam ptr_t NIL = ptr_t'(POOL);

    typedef struct {
        logic [ACTION_BITS-1:0]            act;
        logic signed [PORT_VALUE_BITS-1:0] val;
    } cmd_t;

    logic                              aclk = 1'b0;
    logic                              aresetn = 1'b0;
    logic                              s_valid = 1'b0;
    logic                              s_ready;
    logic [ACTION_BITS-1:0]            s_action = '0;
    logic signed [PORT_VALUE_BITS-1:0] s_value = '0;
    logic                              m_valid;
    logic                              m_ready = 1'b0;
    logic                              m_head_present;
    logic signed [PORT_VALUE_BITS-1:0] m_head_value;
    logic                              m_cursor_active;
    logic signed [PORT_VALUE_BITS-1:0] m_cursor_value;
    logic                              m_out_of_space;

    // List model state
    logic signed [PORT_VALUE_BITS-1:0] node_val [POOL];
    ptr_t                              node_nxt [POOL];
    bit                                node_busy [POOL];
    ptr_t                              head_ptr = NIL;
    ptr_t                              cur_ptr = NIL;

    cmd_t pending_q[$];
    res_t list_state_q[$];
    res_t want;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    int results_seen = 0;
    int full_seen = 0;
    int errors = 0;
    int quiet_cycles = 0;

    singly_linked_list_with_cursor u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_head_present (m_head_present),
        .m_head_value   (m_head_value),
        .m_cursor_active(m_cursor_active),
        .m_cursor_value (m_cursor_value),
        .m_out_of_space (m_out_of_space)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // Take the lowest free node, or NIL when the pool is exhausted
    function automatic ptr_t grab_free_node();
        ptr_t found;
        int   i;
        found = NIL;
        for (i = 0; i < POOL && found == NIL; i++) begin
            if (!node_busy[i])
                found = ptr_t'(i);
        end
        if (found != NIL)
            node_busy[found] = 1'b1;
        return found;
    endfunction

    // Apply one action to the list model and return the resulting list state
    function automatic res_t list_apply(logic [ACTION_BITS-1:0] act,
                                        logic signed [PORT_VALUE_BITS-1:0] val);
        res_t r;
        ptr_t n;
        bit   full;
        full = 1'b0;
        case (act)
            ACT_CLEAR: begin
                foreach (node_busy[i])
                    node_busy[i] = 1'b0;
                head_ptr = NIL;
                cur_ptr = NIL;
            end
            ACT_INS_HEAD: begin
                n = grab_free_node();
                if (n == NIL) begin
                    full = 1'b1;
                end else begin
                    node_val[n] = val;
                    node_nxt[n] = head_ptr;
                    head_ptr = n;
                end
            end
            ACT_CUR_HEAD: cur_ptr = head_ptr;
            ACT_DEL_HEAD: begin
                if (head_ptr != NIL) begin
                    n = head_ptr;
                    if (cur_ptr == n)
                        cur_ptr = NIL;
                    head_ptr = node_nxt[n];
                    node_busy[n] = 1'b0;
                end
            end
            ACT_DEL_AFTER: begin
                if (cur_ptr != NIL && node_nxt[cur_ptr] != NIL) begin
                    n = node_nxt[cur_ptr];
                    node_nxt[cur_ptr] = node_nxt[n];
                    node_busy[n] = 1'b0;
                end
            end
            ACT_INS_AFTER: begin
                if (cur_ptr != NIL) begin
                    n = grab_free_node();
                    if (n == NIL) begin
                        full = 1'b1;
                    end else begin
                        node_val[n] = val;
                        node_nxt[n] = node_nxt[cur_ptr];
                        node_nxt[cur_ptr] = n;
                    end
                end
            end
            ACT_OVERWRITE: begin
                if (cur_ptr != NIL)
                    node_val[cur_ptr] = val;
            end
            ACT_ADVANCE: begin
                if (cur_ptr != NIL)
                    cur_ptr = node_nxt[cur_ptr];
            end
            default: ;
        endcase
        r.head_present  = (head_ptr != NIL);
        r.head_value    = (head_ptr != NIL) ? node_val[head_ptr] : '0;
        r.cursor_active = (cur_ptr != NIL);
        r.cursor_value  = (cur_ptr != NIL) ? node_val[cur_ptr] : '0;
        r.out_of_space  = full;
        return r;
    endfunction

    // Mostly full-range values, with the corner values mixed in
    function automatic logic signed [PORT_VALUE_BITS-1:0] random_value();
        if ($urandom_range(9) != 0)
            return $urandom();
        case ($urandom_range(3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // General action mix: inserts outweigh deletes so lists grow
    function automatic cmd_t random_action();
        cmd_t c;
        int   roll;
        roll = $urandom_range(99);
        c.val = random_value();
        if (roll < 20)
            c.act = ACT_INS_HEAD;
        else if (roll < 35)
            c.act = ACT_INS_AFTER;
        else if (roll < 45)
            c.act = ACT_CUR_HEAD;
        else if (roll < 55)
            c.act = ACT_DEL_HEAD;
        else if (roll < 65)
            c.act = ACT_DEL_AFTER;
        else if (roll < 73)
            c.act = ACT_OVERWRITE;
        else if (roll < 85)
            c.act = ACT_ADVANCE;
        else if (roll < 91)
            c.act = ACT_PEEK;
        else if (roll < 94)
            c.act = ACT_CLEAR;
        else
            c.act = ACTION_BITS'(ACT_RSVD_FIRST
                                 + $urandom_range(ACT_RSVD_LAST - ACT_RSVD_FIRST));
        return c;
    endfunction

    task automatic queue_action(logic [ACTION_BITS-1:0] act,
                                logic signed [PORT_VALUE_BITS-1:0] val);
        cmd_t c;
        c.act = act;
        c.val = val;
        pending_q.push_back(c);
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_q.push_back(random_action());
    endtask

    // Hold until every queued transaction has been sent and answered
    task automatic drain();
        while (pending_q.size() != 0 || s_valid || list_state_q.size() != 0)
            @(negedge aclk);
    endtask

    function automatic void check_field(string name,
                                        logic signed [PORT_VALUE_BITS-1:0] exp_v,
                                        logic signed [PORT_VALUE_BITS-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            errors++;
        end
    endfunction

    // Driver: present the next pending transaction, predict on acceptance
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                list_state_q.push_back(list_apply(s_action, s_value));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid  <= 1'b1;
                    s_action <= pending_q[0].act;
                    s_value  <= pending_q[0].val;
                    void'(pending_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result transaction against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (list_state_q.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    errors++;
                end else begin
                    want = list_state_q.pop_front();
                    if (want.out_of_space)
                        full_seen++;
                    check_field("head_present", PORT_VALUE_BITS'(want.head_present),
                                PORT_VALUE_BITS'(m_head_present));
                    check_field("head_value", want.head_value, m_head_value);
                    check_field("cursor_active", PORT_VALUE_BITS'(want.cursor_active),
                                PORT_VALUE_BITS'(m_cursor_active));
                    check_field("cursor_value", want.cursor_value, m_cursor_value);
                    check_field("out_of_space", PORT_VALUE_BITS'(want.out_of_space),
                                PORT_VALUE_BITS'(m_out_of_space));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: abort when no transaction moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list and inactive cursor first
        queue_action(ACT_PEEK, '0);
        queue_action(ACT_DEL_HEAD, '0);
        queue_action(ACT_ADVANCE, '0);
        queue_action(ACT_OVERWRITE, 32'sh1234_5678);
        queue_action(ACT_INS_AFTER, 32'sh0BAD_F00D);
        queue_action(ACT_DEL_AFTER, '0);
        queue_action(ACT_CUR_HEAD, '0);
        // Build -1, 0, MIN, MAX from the head down
        queue_action(ACT_INS_HEAD, VAL_MAX);
        queue_action(ACT_INS_HEAD, VAL_MIN);
        queue_action(ACT_INS_HEAD, '0);
        queue_action(ACT_INS_HEAD, '1);
        queue_action(ACT_CUR_HEAD, '0);
        queue_action(ACT_OVERWRITE, VAL_MIN);
        queue_action(ACT_INS_AFTER, VAL_MAX);
        queue_action(ACT_ADVANCE, '0);
        queue_action(ACT_DEL_AFTER, '0);
        // Walk to the tail, try to delete past it, then fall off the end
        queue_action(ACT_ADVANCE, '0);
        queue_action(ACT_ADVANCE, '0);
        queue_action(ACT_DEL_AFTER, '0);
        queue_action(ACT_ADVANCE, '0);
        // Delete the head while the cursor sits on it
        queue_action(ACT_CUR_HEAD, '0);
        queue_action(ACT_DEL_HEAD, '0);
        queue_action(ACT_RSVD_FIRST, VAL_MAX);
        queue_action(ACT_RSVD_LAST, VAL_MIN);
        queue_action(ACT_CLEAR, '0);
        queue_random(100);
        drain();

        // Sender idles most cycles
        send_idle_pct = 74;
        recv_stall_pct = 0;
        queue_random(100);
        drain();

        // Receiver stalls while the pool is filled past capacity
        send_idle_pct = 0;
        recv_stall_pct = 74;
        queue_action(ACT_CLEAR, '0);
        queue_action(ACT_INS_HEAD, random_value());
        queue_action(ACT_CUR_HEAD, '0);
        repeat (320) begin
            case ($urandom_range(19))
                0: queue_action(ACT_OVERWRITE, random_value());
                1: queue_action(ACT_PEEK, '0);
                2: queue_action(ACT_CUR_HEAD, '0);
                3, 4, 5, 6, 7, 8, 9, 10: queue_action(ACT_INS_AFTER, random_value());
                default: queue_action(ACT_INS_HEAD, random_value());
            endcase
        end
        // Free nodes from a full pool and reuse them
        queue_action(ACT_DEL_AFTER, '0);
        queue_action(ACT_INS_AFTER, random_value());
        queue_action(ACT_INS_AFTER, random_value());
        queue_action(ACT_DEL_HEAD, '0);
        queue_action(ACT_INS_HEAD, random_value());
        queue_action(ACT_INS_HEAD, random_value());
        queue_random(40);
        drain();

        // Both sides throttled
        send_idle_pct = 31;
        recv_stall_pct = 31;
        queue_action(ACT_CLEAR, '0);
        queue_random(180);
        drain();

        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("%0d list actions sent, %0d results checked, %0d inserts hit a full pool",
                 items_sent, results_seen, full_seen);
        $display("idling phases: none, sender 74%%, receiver 74%%, both 31%%");
        if (errors == 0 && list_state_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
